// ===== rtl/core/plsc_pkg.sv =====
package plsc_pkg;

  // Table geometry.
  localparam int SLOTS   = 16;
  localparam int ID_BITS = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEVELS  = $clog2(SLOTS);
  localparam int CAND_N  = 1 << LEVELS;
  localparam int LVL_W   = $clog2(LEVELS + 1);

  // Field widths fixed by the interface.
  localparam int FUNC_W   = 2;
  localparam int EID_W    = 16;
  localparam int SEL_W    = 4;
  localparam int SOUT_W   = 4;
  localparam int STRIDE_W = 32;
  localparam int PROD_W   = 48;
  localparam int STAMP_W  = 64;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP     = 2'd0,
    FN_RELEASE    = 2'd1,
    FN_INVALIDATE = 2'd2,
    FN_CLEAR      = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 1'b0,
    CFG_STRIDE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    POL_LRU = 1'b0,
    POL_LFU = 1'b1
  } policy_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_REDUCE,
    ST_COMMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic in_ready;
    logic load;
    logic reduce;
    logic commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic req_valid;
    logic req_lookup;
    logic out_free;
  } sts_t;

  // One eviction candidate in the reduction tree.
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] idx;
    logic [CNT_W-1:0]  count;
    logic [STAMP_W-1:0] age;
  } cand_t;

  function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
    sat_inc32 = (v == '1) ? v : v + CNT_W'(1);
  endfunction

  // True when the right (higher index) candidate beats the left one.
  // Equal keys keep the left one, so the lowest index wins ties.
  function automatic logic right_wins(input cand_t l, input cand_t r, input policy_t pol);
    logic better;
    if (pol == POL_LFU) begin
      better = (r.count < l.count) || ((r.count == l.count) && (r.age < l.age));
    end else begin
      better = r.age < l.age;
    end
    right_wins = r.ok && (!l.ok || better);
  endfunction

endpackage

// ===== rtl/core/plsc_req_if.sv =====
interface plsc_req_if import plsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [EID_W-1:0]   entry_id;
  logic [SEL_W-1:0]   slot_sel;

  modport source (output valid, func, entry_id, slot_sel, input ready);
  modport sink   (input valid, func, entry_id, slot_sel, output ready);
endinterface

// ===== rtl/core/plsc_rsp_if.sv =====
interface plsc_rsp_if import plsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SOUT_W-1:0]  slot_out;
  logic               hit;
  logic               status;
  logic [PROD_W-1:0]  fetch_offset;
  logic [CNT_W-1:0]   hits_total;
  logic [CNT_W-1:0]   misses_total;

  modport source (output valid, slot_out, hit, status, fetch_offset, hits_total,
                  misses_total, input ready);
  modport sink   (input valid, slot_out, hit, status, fetch_offset, hits_total,
                  misses_total, output ready);
endinterface

// ===== rtl/core/plsc_ctrl.sv =====
module plsc_ctrl import plsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state;
  state_t           state_next;
  logic [LVL_W-1:0] level_cnt;
  logic [LVL_W-1:0] level_cnt_next;
  logic             last_level;

  assign last_level = (level_cnt == LVL_W'(LEVELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      level_cnt <= '0;
    end else begin
      state     <= state_next;
      level_cnt <= level_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    level_cnt_next = level_cnt;
    case (state)
      ST_IDLE: begin
        if (sts.req_valid) begin
          state_next = sts.req_lookup ? ST_SEARCH : ST_COMMIT;
        end
      end
      ST_SEARCH: begin
        state_next     = ST_REDUCE;
        level_cnt_next = '0;
      end
      ST_REDUCE: begin
        level_cnt_next = level_cnt + LVL_W'(1);
        if (last_level) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:   cmd.in_ready = 1'b1;
      ST_SEARCH: cmd.load     = 1'b1;
      ST_REDUCE: cmd.reduce   = 1'b1;
      ST_COMMIT: cmd.commit   = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/plsc_dpath.sv =====
module plsc_dpath import plsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  input  logic [FUNC_W-1:0]     req_func,
  input  logic [EID_W-1:0]      req_id,
  input  logic [SEL_W-1:0]      req_sel,
  input  logic                  rsp_ready,
  output logic                  rsp_valid,
  output logic [SOUT_W-1:0]     rsp_slot,
  output logic                  rsp_hit,
  output logic                  rsp_status,
  output logic [PROD_W-1:0]     rsp_offset,
  output logic [CNT_W-1:0]      rsp_hits,
  output logic [CNT_W-1:0]      rsp_misses
);

  policy_t               policy;
  logic [STRIDE_W-1:0]   entry_stride;

  func_t                 op_func;
  logic [ID_BITS-1:0]    op_id;
  logic [SEL_W-1:0]      op_sel;

  logic [ID_BITS-1:0]    slot_tag   [SLOTS];
  logic [SLOTS-1:0]      slot_valid;
  logic [SLOTS-1:0]      slot_pinned;
  logic [STAMP_W-1:0]    slot_age   [SLOTS];
  logic [CNT_W-1:0]      slot_uses  [SLOTS];

  logic [STAMP_W-1:0]    lookup_clock;
  logic [CNT_W-1:0]      hit_counter;
  logic [CNT_W-1:0]      miss_counter;
  logic [CNT_W-1:0]      hit_counter_next;
  logic [CNT_W-1:0]      miss_counter_next;

  logic                  hit_found;
  logic [SLOT_W-1:0]     hit_idx;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic [PROD_W-1:0]     product;

  cand_t                 cand     [CAND_N];
  cand_t                 cand_red [CAND_N/2];

  logic [SLOTS-1:0]      match_vec;
  logic [SLOTS-1:0]      free_vec;
  logic                  match_any;
  logic [SLOT_W-1:0]     match_pos;
  logic                  free_any;
  logic [SLOT_W-1:0]     free_pos;

  logic                  is_lookup;
  logic                  victim_ok;
  logic [SLOT_W-1:0]     victim_idx;
  logic                  upd_hit;
  logic                  upd_fill;
  logic [SLOT_W-1:0]     upd_idx;
  logic                  sel_in_range;

  assign sts.req_valid  = req_valid;
  assign sts.req_lookup = (func_t'(req_func) == FN_LOOKUP);
  assign sts.out_free   = !rsp_valid || rsp_ready;

  // Search over the live tag lanes.
  always_comb begin
    match_any = 1'b0;
    match_pos = '0;
    free_any  = 1'b0;
    free_pos  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = slot_valid[i] && (slot_tag[i] == op_id);
      free_vec[i]  = !slot_valid[i] && !slot_pinned[i];
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_any = 1'b1;
        match_pos = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_any = 1'b1;
        free_pos = SLOT_W'(i);
      end
    end
  end

  // One level of the pairwise reduction tree.
  always_comb begin
    for (int i = 0; i < CAND_N / 2; i++) begin
      cand_red[i] = right_wins(cand[2*i], cand[2*i+1], policy) ? cand[2*i+1] : cand[2*i];
    end
  end

  assign is_lookup    = (op_func == FN_LOOKUP);
  assign victim_ok    = free_found || cand[0].ok;
  assign victim_idx   = free_found ? free_idx : cand[0].idx;
  assign upd_hit      = is_lookup && hit_found;
  assign upd_fill     = is_lookup && !hit_found && victim_ok;
  assign upd_idx      = hit_found ? hit_idx : victim_idx;
  assign sel_in_range = (int'(op_sel) < SLOTS);

  always_comb begin
    hit_counter_next  = hit_counter;
    miss_counter_next = miss_counter;
    case (op_func)
      FN_LOOKUP: begin
        if (hit_found) begin
          hit_counter_next = sat_inc32(hit_counter);
        end else begin
          miss_counter_next = sat_inc32(miss_counter);
        end
      end
      FN_CLEAR: begin
        hit_counter_next  = '0;
        miss_counter_next = '0;
      end
      default: begin
        hit_counter_next  = hit_counter;
        miss_counter_next = miss_counter;
      end
    endcase
  end

  // Configuration and the accepted operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= POL_LRU;
      entry_stride <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_POLICY: policy       <= policy_t'(cfg_data[0]);
        CFG_STRIDE: entry_stride <= STRIDE_W'(cfg_data);
        default:    policy       <= policy;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && cmd.in_ready) begin
      op_func <= func_t'(req_func);
      op_id   <= ID_BITS'(req_id);
      op_sel  <= req_sel;
    end
  end

  // Search results, offset product and tree.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_found <= match_any;
      hit_idx   <= match_pos;
      free_found <= free_any;
      free_idx   <= free_pos;
      product    <= PROD_W'(op_id) * PROD_W'(entry_stride);
      for (int i = 0; i < SLOTS; i++) begin
        cand[i].ok    <= !slot_pinned[i];
        cand[i].idx   <= SLOT_W'(i);
        cand[i].count <= slot_uses[i];
        cand[i].age   <= slot_age[i];
      end
      for (int i = SLOTS; i < CAND_N; i++) begin
        cand[i] <= '0;
      end
    end else if (cmd.reduce) begin
      for (int i = 0; i < CAND_N / 2; i++) begin
        cand[i] <= cand_red[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_clock <= '0;
    end else if (cmd.load) begin
      lookup_clock <= lookup_clock + STAMP_W'(1);
    end
  end

  // Slot lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      slot_pinned <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_age[i]  <= '0;
        slot_uses[i] <= '0;
      end
      hit_counter  <= '0;
      miss_counter <= '0;
    end else if (cmd.commit) begin
      hit_counter  <= hit_counter_next;
      miss_counter <= miss_counter_next;
      for (int i = 0; i < SLOTS; i++) begin
        if ((upd_hit || upd_fill) && (upd_idx == SLOT_W'(i))) begin
          slot_age[i]    <= lookup_clock;
          slot_pinned[i] <= 1'b1;
          if (upd_fill) begin
            slot_tag[i]   <= op_id;
            slot_valid[i] <= 1'b1;
            slot_uses[i]  <= CNT_W'(1);
          end else begin
            slot_uses[i] <= sat_inc32(slot_uses[i]);
          end
        end
        if (sel_in_range && (int'(op_sel) == i)) begin
          if (op_func == FN_RELEASE) begin
            slot_pinned[i] <= 1'b0;
          end
          if (op_func == FN_INVALIDATE) begin
            slot_valid[i] <= 1'b0;
            slot_uses[i]  <= '0;
          end
        end
        if (op_func == FN_CLEAR) begin
          slot_valid[i] <= 1'b0;
          slot_age[i]   <= '0;
          slot_uses[i]  <= '0;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_slot   <= (upd_hit || upd_fill) ? SOUT_W'(upd_idx) : '0;
      rsp_hit    <= upd_hit;
      rsp_status <= is_lookup && !hit_found && !victim_ok;
      rsp_offset <= upd_fill ? product : '0;
      rsp_hits   <= hit_counter_next;
      rsp_misses <= miss_counter_next;
    end
  end

endmodule

// ===== rtl/core/pinned_lru_lfu_slot_cache.sv =====
// Channel   Direction  Payload                                          Transfer when
// req       in         func, entry_id, slot_sel                         valid && ready
// rsp       out        slot_out, hit, status, fetch_offset,             valid && ready
//                      hits_total, misses_total
// cfg       in         cfg_idx (0 policy, 1 entry_stride), cfg_data     cfg_we
//
// A lookup goes from its transfer through a search state over all tag lanes, the reduction
// state once for each level of the victim tree and a commit state that writes the result
// register; the controller then returns to idle before it takes another request. Release,
// invalidate and clear go from idle straight to the commit state. A new request is taken
// while an earlier result waits; its commit waits until that result has left.
// Synchronous active-high reset empties and unpins every slot; no request is taken.
module pinned_lru_lfu_slot_cache import plsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  plsc_req_if.sink              req,
  plsc_rsp_if.source            rsp
);

  // The controller sequences search, tree reduction and commit; the datapath
  // holds the slot lanes, the statistics and the output register.
  cmd_t cmd;
  sts_t sts;

  plsc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Requests are taken only in the idle state of the controller, and never in reset.
  assign req.ready = cmd.in_ready && !rst;

  plsc_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .req_valid  (req.valid),
    .req_func   (req.func),
    .req_id     (req.entry_id),
    .req_sel    (req.slot_sel),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .rsp_slot   (rsp.slot_out),
    .rsp_hit    (rsp.hit),
    .rsp_status (rsp.status),
    .rsp_offset (rsp.fetch_offset),
    .rsp_hits   (rsp.hits_total),
    .rsp_misses (rsp.misses_total)
  );

endmodule

// ===== rtl/core/plsc_chk.sv =====
module plsc_chk import plsc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [SOUT_W-1:0] rsp_slot,
  input logic              rsp_hit,
  input logic              rsp_status,
  input logic [PROD_W-1:0] rsp_offset
);

  // A pending result is never withdrawn.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // One operation at a time: the request side closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while one is in progress");

  a_full_pin_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> !rsp_hit && (rsp_slot == '0) && (rsp_offset == '0))
    else $error("all-pinned result carries a slot or an offset");

  a_hit_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |-> !rsp_status && (rsp_offset == '0))
    else $error("hit result carries an error or an offset");

endmodule

bind pinned_lru_lfu_slot_cache plsc_chk u_plsc_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_slot   (rsp.slot_out),
  .rsp_hit    (rsp.hit),
  .rsp_status (rsp.status),
  .rsp_offset (rsp.fetch_offset)
);
